// ===== sv/tpa_pkg.sv =====
// Shared types and constants of the triangle perimeter and area block.
`timescale 1ns / 1ps
package tpa_pkg;

  localparam int CoordBits = 16;
  localparam int LenW      = 25;
  localparam int PerW      = 27;
  localparam int AreaW     = 40;

  typedef struct packed {
    logic signed [CoordBits-1:0] line1_start_x;
    logic signed [CoordBits-1:0] line1_start_y;
    logic signed [CoordBits-1:0] line1_end_x;
    logic signed [CoordBits-1:0] line1_end_y;
    logic signed [CoordBits-1:0] line2_start_x;
    logic signed [CoordBits-1:0] line2_start_y;
    logic signed [CoordBits-1:0] line2_end_x;
    logic signed [CoordBits-1:0] line2_end_y;
    logic signed [CoordBits-1:0] line3_start_x;
    logic signed [CoordBits-1:0] line3_start_y;
    logic signed [CoordBits-1:0] line3_end_x;
    logic signed [CoordBits-1:0] line3_end_y;
  } in_t;

  typedef struct packed {
    logic             is_triangle;
    logic [LenW-1:0]  length_one;
    logic [LenW-1:0]  length_two;
    logic [LenW-1:0]  length_three;
    logic [PerW-1:0]  perimeter;
    logic [AreaW-1:0] area;
  } out_t;

  // Absolute coordinate differences of the three segments.
  typedef struct packed {
    logic [CoordBits-1:0] dx1;
    logic [CoordBits-1:0] dy1;
    logic [CoordBits-1:0] dx2;
    logic [CoordBits-1:0] dy2;
    logic [CoordBits-1:0] dx3;
    logic [CoordBits-1:0] dy3;
  } diff_t;

endpackage

// ===== sv/triangle_perimeter_area_top.sv =====
// Top level of the triangle perimeter and Heron area block.
`timescale 1ns / 1ps
// Usage: the block looks like a queue on both sides. A request of three line
// segments (twelve signed coordinates) is taken at a rising edge with push high
// and full low. The oldest result waits on res_o while empty is low and is
// taken at a rising edge with pop high and empty low.
// Each result gives the three segment lengths and the perimeter in unsigned
// fixed point with FRAC_BITS fraction bits, a strict triangle flag and the
// Heron area, which is zero when the flag is clear.
// Throughput: one request per cycle while the receiver keeps popping. Both
// square root pipelines are bit-per-stage: the length root has one stage per
// result bit, the area root one stage per bit of its 2*(length width + 2) bit
// result. A request passes the front register, the middle queue, the square
// and radicand registers, the length root, the Heron product registers, the
// area root and the result queue, in that order.
// The front stage and the back pipeline are parted by a two-entry queue, and
// the results leave through a two-entry queue. When the receiver stops popping
// the back pipeline freezes as a whole, the middle queue fills, and then full
// rises; no request is lost. Reset clears all valid state, so the block starts
// empty and ready.
module triangle_perimeter_area_top
  import tpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  input  in_t  in_data_i,
  output logic full,
  input  logic pop,
  output out_t res_o,
  output logic empty
);
  logic  fe_valid, q_full, q_empty, be_pop, be_push, o_full;
  diff_t fe_diff, q_diff;
  out_t  be_res;

  // Front stage: differences of the coordinates.
  tpa_front u_front (
    .clk_i, .rst_ni, .push_i(push), .in_data_i, .full_o(full),
    .valid_o(fe_valid), .diff_o(fe_diff), .qfull_i(q_full)
  );

  // Decoupling queue between the front and the back.
  tpa_fifo #(.Width($bits(diff_t)), .Depth(2)) u_mid_q (
    .clk_i, .rst_ni, .push_i(fe_valid), .wdata_i(fe_diff), .full_o(q_full),
    .pop_i(be_pop), .rdata_o(q_diff), .empty_o(q_empty)
  );

  // Back pipeline: squares, roots and the Heron product.
  tpa_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(!q_empty), .diff_i(q_diff), .pop_o(be_pop),
    .push_o(be_push), .res_o(be_res), .ofull_i(o_full)
  );

  // Result queue seen by the receiver.
  tpa_fifo #(.Width($bits(out_t)), .Depth(2)) u_out_q (
    .clk_i, .rst_ni, .push_i(be_push), .wdata_i(be_res), .full_o(o_full),
    .pop_i(pop), .rdata_o(res_o), .empty_o(empty)
  );

  // A result that is not a triangle never carries an area.
  a_area_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.is_triangle) |-> (res_o.area == '0))
    else $error("area set on a non-triangle");

  // The triangle flag agrees with the lengths that are shown.
  a_tri_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.is_triangle) |->
      ((PerW'(res_o.length_one) < PerW'(res_o.length_two) + PerW'(res_o.length_three)) &&
       (PerW'(res_o.length_two) < PerW'(res_o.length_one) + PerW'(res_o.length_three))))
    else $error("triangle flag disagrees with lengths");

  // The perimeter is the sum of the three lengths shown.
  a_perim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (res_o.perimeter == PerW'(PerW'(res_o.length_one) +
                PerW'(res_o.length_two) + PerW'(res_o.length_three))))
    else $error("perimeter is not the sum of the lengths");
endmodule

// ===== sv/tpa_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
module tpa_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

// ===== sv/tpa_front.sv =====
// Front end: takes requests and forms the absolute coordinate differences.
`timescale 1ns / 1ps
module tpa_front
  import tpa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  in_t   in_data_i,
  output logic  full_o,
  output logic  valid_o,
  output diff_t diff_o,
  input  logic  qfull_i
);
  logic  valid_q;
  diff_t diff_q, diff_d;
  logic  ready;

  function automatic logic [CoordBits-1:0] absdiff(logic signed [CoordBits-1:0] a,
                                                    logic signed [CoordBits-1:0] b);
    logic signed [CoordBits:0] d;
    logic signed [CoordBits:0] n;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    n = -d;
    return d[CoordBits] ? n[CoordBits-1:0] : d[CoordBits-1:0];
  endfunction

  always_comb begin
    diff_d.dx1 = absdiff(in_data_i.line1_start_x, in_data_i.line1_end_x);
    diff_d.dy1 = absdiff(in_data_i.line1_start_y, in_data_i.line1_end_y);
    diff_d.dx2 = absdiff(in_data_i.line2_start_x, in_data_i.line2_end_x);
    diff_d.dy2 = absdiff(in_data_i.line2_start_y, in_data_i.line2_end_y);
    diff_d.dx3 = absdiff(in_data_i.line3_start_x, in_data_i.line3_end_x);
    diff_d.dy3 = absdiff(in_data_i.line3_start_y, in_data_i.line3_end_y);
  end

  assign ready   = !valid_q || !qfull_i;
  assign full_o  = !ready;
  assign valid_o = valid_q;
  assign diff_o  = diff_q;

  always_ff @(posedge clk_i) begin
    if (push_i && ready) begin
      diff_q <= diff_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= push_i;
    end
  end
endmodule

// ===== sv/tpa_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, over one or more lanes.
`timescale 1ns / 1ps
module tpa_isqrt #(
  parameter int InW   = 8,
  parameter int Lanes = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [Lanes-1:0][InW-1:0]            rad_i,
  output logic                                 valid_o,
  output logic [Lanes-1:0][(InW+1)/2-1:0]      root_o
);
  localparam int Steps = (InW + 1) / 2;
  localparam int N     = 2 * Steps;

  logic [N-1:0]     rem_q [Steps][Lanes];
  logic [N-1:0]     res_q [Steps][Lanes];
  logic [Steps-1:0] vld_q;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [N-1:0] Bit = N'(1) << (2 * (Steps - 1 - k));
    for (genvar j = 0; j < Lanes; j++) begin : g_lane
      logic [N-1:0] rem_p, res_p, trial, rem_d, res_d;
      if (k == 0) begin : g_first
        assign rem_p = N'(rad_i[j]);
        assign res_p = '0;
      end else begin : g_next
        assign rem_p = rem_q[k-1][j];
        assign res_p = res_q[k-1][j];
      end
      assign trial = res_p + Bit;
      always_comb begin
        if (rem_p >= trial) begin
          rem_d = rem_p - trial;
          res_d = (res_p >> 1) + Bit;
        end else begin
          rem_d = rem_p;
          res_d = res_p >> 1;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][j] <= rem_d;
          res_q[k][j] <= res_d;
        end
      end
    end
  end

  for (genvar j = 0; j < Lanes; j++) begin : g_out
    assign root_o[j] = res_q[Steps-1][j][Steps-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[Steps-1];
endmodule

// ===== sv/tpa_back.sv =====
// Back end: squares, length roots, Heron product and area root.
`timescale 1ns / 1ps
module tpa_back
  import tpa_pkg::*;
#(
  parameter int FracBits = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  diff_t diff_i,
  output logic  pop_o,
  output logic  push_o,
  output out_t  res_o,
  input  logic  ofull_i
);
  localparam int SqW   = 2 * CoordBits;
  localparam int RadW  = SqW + 1 + 2 * FracBits;
  localparam int LW    = (RadW + 1) / 2;
  localparam int PW    = LW + 2;
  localparam int ProdW = 4 * PW;
  localparam int AL    = (ProdW + 1) / 2;
  localparam int SideW = 1 + 3 * LW + PW;

  logic en;
  logic area_vld;

  // Stage 1: squares.
  logic          s1_vld_q;
  logic [SqW-1:0] sq_q [6];
  // Stage 2: shifted radicands.
  logic          s2_vld_q;
  logic [2:0][RadW-1:0] rad_q;
  // Length roots.
  logic          len_vld;
  logic [2:0][LW-1:0] len;
  // Stage 3: perimeter and Heron factors.
  logic          s3_vld_q;
  logic [PW-1:0] p_q, u1_q, u2_q, u3_q;
  logic [SideW-1:0] s3_side_q;
  logic [PW-1:0] p_d;
  logic          tri_d;
  // Stage 4..6: product in partial products.
  logic            s4_vld_q, s5_vld_q, s6_vld_q;
  logic [2*PW-1:0] x_q, y_q;
  logic [2*PW-1:0] hh_q, hl_q, lh_q, ll_q;
  logic [ProdW-1:0] prod_q;
  logic [SideW-1:0] s4_side_q, s5_side_q, s6_side_q;
  logic [SideW-1:0] side_q [AL];
  // Area root.
  logic [0:0][AL-1:0] area_root;
  logic [AL-1:0]      area_sh;
  logic [SideW-1:0]   side_o;

  assign en    = !(area_vld && ofull_i);
  assign pop_o = en && valid_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= diff_i.dx1 * diff_i.dx1;
      sq_q[1] <= diff_i.dy1 * diff_i.dy1;
      sq_q[2] <= diff_i.dx2 * diff_i.dx2;
      sq_q[3] <= diff_i.dy2 * diff_i.dy2;
      sq_q[4] <= diff_i.dx3 * diff_i.dx3;
      sq_q[5] <= diff_i.dy3 * diff_i.dy3;
      for (int i = 0; i < 3; i++) begin
        rad_q[i] <= (RadW'(sq_q[2*i]) + RadW'(sq_q[2*i+1])) << (2 * FracBits);
      end
    end
  end

  tpa_isqrt #(.InW(RadW), .Lanes(3)) u_len_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_vld_q), .rad_i(rad_q),
    .valid_o(len_vld), .root_o(len)
  );

  assign p_d   = PW'(len[0]) + PW'(len[1]) + PW'(len[2]);
  assign tri_d = (PW'(len[0]) < PW'(len[1]) + PW'(len[2])) &&
                 (PW'(len[1]) < PW'(len[0]) + PW'(len[2])) &&
                 (PW'(len[2]) < PW'(len[0]) + PW'(len[1]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q       <= p_d;
      u1_q      <= p_d - {len[0], 1'b0};
      u2_q      <= p_d - {len[1], 1'b0};
      u3_q      <= p_d - {len[2], 1'b0};
      s3_side_q <= {tri_d, len[0], len[1], len[2], p_d};
      x_q       <= (2*PW)'(p_q) * (2*PW)'(u1_q);
      y_q       <= (2*PW)'(u2_q) * (2*PW)'(u3_q);
      s4_side_q <= s3_side_q;
      hh_q      <= (2*PW)'(x_q[2*PW-1:PW]) * (2*PW)'(y_q[2*PW-1:PW]);
      hl_q      <= (2*PW)'(x_q[2*PW-1:PW]) * (2*PW)'(y_q[PW-1:0]);
      lh_q      <= (2*PW)'(x_q[PW-1:0]) * (2*PW)'(y_q[2*PW-1:PW]);
      ll_q      <= (2*PW)'(x_q[PW-1:0]) * (2*PW)'(y_q[PW-1:0]);
      s5_side_q <= s4_side_q;
      prod_q    <= (ProdW'(hh_q) << (2 * PW)) + (ProdW'(hl_q) << PW) +
                   (ProdW'(lh_q) << PW) + ProdW'(ll_q);
      s6_side_q <= s5_side_q;
      side_q[0] <= s6_side_q;
      for (int i = 1; i < AL; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  tpa_isqrt #(.InW(ProdW), .Lanes(1)) u_area_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s6_vld_q), .rad_i(prod_q),
    .valid_o(area_vld), .root_o(area_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= len_vld;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  assign side_o  = side_q[AL-1];
  assign area_sh = area_root[0] >> (FracBits + 2);

  always_comb begin
    res_o.is_triangle  = side_o[SideW-1];
    res_o.length_one   = LenW'(side_o[PW+3*LW-1:PW+2*LW]);
    res_o.length_two   = LenW'(side_o[PW+2*LW-1:PW+LW]);
    res_o.length_three = LenW'(side_o[PW+LW-1:PW]);
    res_o.perimeter    = PerW'(side_o[PW-1:0]);
    res_o.area         = side_o[SideW-1] ? AreaW'(area_sh) : '0;
  end

  assign push_o = area_vld;
endmodule
